// ----- rtl/core/ubd_pkg.sv -----
// shared types and codes for the utf-16 byte order mark detecting decoder
// no dependencies
package ubd_pkg;

  // byte order mode register codes
  localparam logic [1:0] MODE_DETECT = 2'd0;
  localparam logic [1:0] MODE_BIG    = 2'd1;
  localparam logic [1:0] MODE_LITTLE = 2'd2;

  // detector phase codes, 5..7 act as the initial phase
  localparam logic [2:0] PH_INIT   = 3'd0;
  localparam logic [2:0] PH_SAW_FE = 3'd1;
  localparam logic [2:0] PH_SAW_FF = 3'd2;
  localparam logic [2:0] PH_BIG    = 3'd3;
  localparam logic [2:0] PH_LITTLE = 3'd4;

  // reported order codes
  localparam logic [1:0] ORD_NONE   = 2'd0;
  localparam logic [1:0] ORD_BIG    = 2'd1;
  localparam logic [1:0] ORD_LITTLE = 2'd2;

  localparam logic [7:0] MARK_FE = 8'hfe;
  localparam logic [7:0] MARK_FF = 8'hff;

  typedef struct packed {
    logic [2:0] phase;
    logic       held_valid;
    logic [7:0] held_byte;
  } state_t;

  typedef struct packed {
    logic [1:0]  order_found;
    logic        truncated;
    logic        unit_valid;
    logic [15:0] code_unit;
  } result_t;

  localparam state_t STATE_CLEAR = '{phase: PH_INIT, held_valid: 1'b0, held_byte: 8'h00};

endpackage

// ----- rtl/core/ubd_step.sv -----
// one decoding step: mark detection, byte pairing and flush handling
// depends on ubd_pkg
module ubd_step (
  input  logic [1:0]      mode,
  input  ubd_pkg::state_t state,
  input  logic [7:0]      data_byte,
  input  logic            has_byte,
  input  logic            flush,
  output ubd_pkg::state_t state_next,
  output ubd_pkg::result_t result
);
  import ubd_pkg::*;

  logic [2:0]  ph;
  logic        do_pair;
  logic        little;
  logic        hv_use;
  logic [7:0]  hb_use;
  logic        hv;
  logic [7:0]  hb;
  logic [15:0] unit;
  logic        valid;
  logic [1:0]  order;
  logic        fixed_mode;

  assign fixed_mode = (mode == MODE_BIG) || (mode == MODE_LITTLE);

  always_comb begin
    ph      = state.phase;
    do_pair = 1'b0;
    little  = 1'b0;
    hv_use  = state.held_valid;
    hb_use  = state.held_byte;
    if (fixed_mode) begin
      do_pair = has_byte;
      little  = (mode == MODE_LITTLE);
    end else if (has_byte) begin
      unique case (state.phase)
        PH_SAW_FE, PH_SAW_FF: begin
          if (data_byte == ((state.phase == PH_SAW_FE) ? MARK_FF : MARK_FE)) begin
            ph = (state.phase == PH_SAW_FE) ? PH_BIG : PH_LITTLE;
          end else begin
            // broken mark: its first byte becomes the high byte
            ph      = PH_BIG;
            do_pair = 1'b1;
            hv_use  = 1'b1;
            hb_use  = (state.phase == PH_SAW_FE) ? MARK_FE : MARK_FF;
          end
        end
        PH_BIG: begin
          do_pair = 1'b1;
        end
        PH_LITTLE: begin
          do_pair = 1'b1;
          little  = 1'b1;
        end
        default: begin
          if (data_byte == MARK_FE) begin
            ph = PH_SAW_FE;
          end else if (data_byte == MARK_FF) begin
            ph = PH_SAW_FF;
          end else begin
            ph      = PH_BIG;
            do_pair = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    hv    = state.held_valid;
    hb    = state.held_byte;
    unit  = 16'h0000;
    valid = 1'b0;
    if (do_pair) begin
      if (hv_use) begin
        unit  = little ? {data_byte, hb_use} : {hb_use, data_byte};
        valid = 1'b1;
        hv    = 1'b0;
        hb    = 8'h00;
      end else begin
        hv = 1'b1;
        hb = data_byte;
      end
    end
  end

  always_comb begin
    if (fixed_mode) begin
      order = (mode == MODE_LITTLE) ? ORD_LITTLE : ORD_BIG;
    end else if (ph == PH_BIG) begin
      order = ORD_BIG;
    end else if (ph == PH_LITTLE) begin
      order = ORD_LITTLE;
    end else begin
      order = ORD_NONE;
    end
  end

  always_comb begin
    result.code_unit   = unit;
    result.unit_valid  = valid;
    result.order_found = order;
    result.truncated   = flush && (hv || ph == PH_SAW_FE || ph == PH_SAW_FF);
    if (flush) begin
      state_next = STATE_CLEAR;
    end else begin
      state_next.phase      = ph;
      state_next.held_valid = hv;
      state_next.held_byte  = hb;
    end
  end

endmodule

// ----- rtl/core/utf16_bom_detect_byte_decoder.sv -----
// top level of the utf-16 byte order mark detecting decoder: input register,
// step logic, result register and the mode register
// depends on ubd_pkg and ubd_step
// a byte passes the input register and then the result register before its result shows on m_tvalid
// throughput: one byte per cycle while m_tready does not stall the result register; the phase and held byte
// registers feed the next step directly, so consecutive bytes need no gap
// reset (rst, synchronous): mode back to detect, detector to its initial state,
// both register stages empty
module utf16_bom_detect_byte_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] has_byte
  input  logic        s_tlast,   // flush
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic [3:0]  m_tuser,   // [0] unit_valid, [1] truncated, [3:2] order_found
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);
  import ubd_pkg::*;

  logic [1:0] mode;
  state_t     state;
  state_t     state_next;
  result_t    result;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_has;
  logic       in_flush;
  logic       advance;

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = !in_valid && !m_tvalid;

  ubd_step u_step (
    .mode       (mode),
    .state      (state),
    .data_byte  (in_byte),
    .has_byte   (in_has),
    .flush      (in_flush),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_DETECT;
      state    <= STATE_CLEAR;
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        // a mode write also restarts detection
        mode  <= cfg_data;
        state <= STATE_CLEAR;
      end else if (in_valid && advance) begin
        state <= state_next;
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_has   <= s_tuser;
      in_flush <= s_tlast;
    end
    if (in_valid && advance) begin
      m_tdata <= result.code_unit;
      m_tuser <= {result.order_found, result.truncated, result.unit_valid};
    end
  end

endmodule

// ----- rtl/core/ubd_checker.sv -----
// port-level checks for the utf-16 byte order mark detecting decoder
// bound to utf16_bom_detect_byte_decoder; no other dependencies
module ubd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [3:0]  m_tuser
);

  // no code unit value without a completed unit
  a_unit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 16'h0000)
    else $error("code unit nonzero without unit_valid");

  // order code three is never reported
  a_order_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[3:2] != 2'd3)
    else $error("invalid order code");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind utf16_bom_detect_byte_decoder ubd_checker u_ubd_checker (.*);
